// ===== rtl/core/rau_pkg.sv =====
// rau_pkg: shared types, opcodes and status codes for the rational unit
// no dependencies
package rau_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_LT  = 3'd4;
	localparam logic [2:0] OP_EQ  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIV0 = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	// request classes set by the front
	localparam logic [1:0] CLS_ARITH = 2'd0;
	localparam logic [1:0] CLS_CMP   = 2'd1;
	localparam logic [1:0] CLS_NONE  = 2'd2;
	localparam logic [1:0] CLS_ERR   = 2'd3;

	// back-end sequencer states
	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SUM,
		B_GCD,
		B_DIV,
		B_CHECK,
		B_OUT
	} back_state_t;

endpackage

// ===== rtl/core/rau_front.sv =====
// rau_front: accepts requests, sign-extends and masks operands, classifies
// depends on rau_pkg
module rau_front
	import rau_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [2:0]             in_type,
	input  logic [31:0]            in_a_num,
	input  logic [30:0]            in_a_den,
	input  logic [31:0]            in_b_num,
	input  logic [30:0]            in_b_den,
	output logic                   q_valid,
	input  logic                   q_pop,
	output logic [2:0]             q_type,
	output logic [1:0]             q_class,
	output logic signed [32:0]     q_a_num,
	output logic signed [32:0]     q_a_den,
	output logic signed [32:0]     q_b_num,
	output logic signed [32:0]     q_b_den
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	// class: arithmetic, compare, unused opcode, divide error
	localparam int unsigned EW = 3 + 2 + 4 * 33;

	logic [EW-1:0]  mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wp_q, rp_q;
	logic [PW:0]    cnt_q;
	logic           push;
	logic signed [32:0] an, ad, bn, bd;
	logic [1:0]     cls;
	logic [EW-1:0]  rd;

	// operand extraction at value width
	always_comb begin
		an = 33'(signed'(in_a_num[VALUE_WIDTH-1:0]));
		bn = 33'(signed'(in_b_num[VALUE_WIDTH-1:0]));
		ad = 33'(in_a_den[VALUE_WIDTH-2:0]);
		bd = 33'(in_b_den[VALUE_WIDTH-2:0]);
		if (in_type == OP_LT || in_type == OP_EQ) begin
			cls = CLS_CMP;
		end else if (in_type > OP_EQ) begin
			cls = CLS_NONE;
		end else if (ad == '0 || bd == '0 || (in_type == OP_DIV && bn == '0)) begin
			cls = CLS_ERR;
		end else begin
			cls = CLS_ARITH;
		end
	end

	assign in_stall = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= {in_type, cls, an, ad, bn, bd};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= PW'((wp_q == PW'(QUEUE_DEPTH-1)) ? 0 : wp_q + 1'b1);
			end
			if (q_pop) begin
				rp_q <= PW'((rp_q == PW'(QUEUE_DEPTH-1)) ? 0 : rp_q + 1'b1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(q_pop);
		end
	end

	assign rd = mem_q[rp_q];
	assign {q_type, q_class, q_a_num, q_a_den, q_b_num, q_b_den} = rd;

endmodule

// ===== rtl/core/rau_back.sv =====
// rau_back: cross products, binary gcd, iterative reduction and range check
// depends on rau_pkg
module rau_back
	import rau_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  logic [2:0]         q_type,
	input  logic [1:0]         q_class,
	input  logic signed [32:0] q_a_num,
	input  logic signed [32:0] q_a_den,
	input  logic signed [32:0] q_b_num,
	input  logic signed [32:0] q_b_den,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        res_num,
	output logic [30:0]        res_den,
	output logic               cmp_true,
	output logic [1:0]         status
);

	localparam int unsigned MW = 66;
	localparam int unsigned CW = $clog2(MW + 1);

	back_state_t st_q, st_d;
	logic [2:0]  op_q;
	logic signed [65:0] p0_q, p1_q, p2_q;
	logic        neg_q;
	logic [63:0] n_q, d_q, x_q, y_q, g_q, rem_q, quo_q, dividend_q;
	logic [6:0]  sh_q;
	logic [CW-1:0] bit_q;
	logic        div_den_q;
	logic [31:0] rn_q;
	logic [30:0] rd_q;
	logic        rc_q;
	logic [1:0]  rs_q;
	logic [64:0] rtry;
	logic [64:0] lim;
	logic        num_zero;
	logic signed [32:0] m0a, m0b, m1a, m1b;
	logic signed [65:0] m0, m1;

	// two multipliers, operands chosen per opcode
	always_comb begin
		m0a = q_a_num; m0b = q_b_den;
		m1a = q_a_den; m1b = q_b_num;
		if (q_type == OP_MUL) begin
			m0b = q_b_num; m1b = q_b_den;
		end
	end
	assign m0 = m0a * m0b;
	assign m1 = m1a * m1b;
	assign lim = 65'(1) << (VALUE_WIDTH - 1);

	// zero numerator from the cross products
	assign num_zero = (op_q == OP_ADD) ? ((p0_q + p1_q) == '0) :
		(op_q == OP_SUB) ? (p0_q == p1_q) : (p0_q == '0);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: if (q_valid) begin
				st_d = (q_class == CLS_ARITH || q_class == CLS_CMP) ? B_MUL : B_OUT;
			end
			B_MUL: st_d = B_SUM;
			B_SUM: st_d = (op_q == OP_LT || op_q == OP_EQ || num_zero) ? B_OUT : B_GCD;
			B_GCD: if (y_q == '0) st_d = B_DIV;
			B_DIV: if (bit_q == '0 && div_den_q) st_d = B_CHECK;
			B_CHECK: st_d = B_OUT;
			B_OUT: if (!out_stall) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	// outputs; the queue head stays put until the products are taken
	always_comb begin
		q_pop     = (st_q == B_MUL) || ((st_q == B_IDLE) && q_valid &&
			(q_class == CLS_NONE || q_class == CLS_ERR));
		out_valid = (st_q == B_OUT);
		res_num   = rn_q;
		res_den   = rd_q;
		cmp_true  = rc_q;
		status    = rs_q;
	end

	assign rtry = {rem_q, dividend_q[63]} - {1'b0, g_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= B_IDLE;
		else st_q <= st_d;
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: if (q_valid) begin
				op_q <= q_type;
				rn_q <= '0; rd_q <= '0; rc_q <= 1'b0;
				rs_q <= (q_class == CLS_ERR) ? ST_DIV0 : ST_OK;
			end
			B_MUL: begin
				p0_q <= m0; p1_q <= m1;
				p2_q <= (op_q == OP_DIV) ? m1 : (q_a_den * q_b_den);
			end
			B_SUM: begin
				logic signed [65:0] nn, dd;
				if (op_q == OP_LT) rc_q <= p0_q < p1_q;
				else if (op_q == OP_EQ) rc_q <= p0_q == p1_q;
				nn = (op_q == OP_ADD) ? p0_q + p1_q :
					(op_q == OP_SUB) ? p0_q - p1_q : p0_q;
				dd = (op_q == OP_DIV) ? p1_q : p2_q;
				if (op_q == OP_MUL) begin
					nn = p0_q; dd = p1_q;
				end
				neg_q <= nn[65] ^ dd[65];
				n_q <= 64'(nn[65] ? -nn : nn);
				d_q <= 64'(dd[65] ? -dd : dd);
				x_q <= 64'(nn[65] ? -nn : nn);
				y_q <= 64'(dd[65] ? -dd : dd);
				sh_q <= '0;
				if (op_q != OP_LT && op_q != OP_EQ && nn == '0) rd_q <= 31'd1;
			end
			B_GCD: begin
				// binary gcd, one step per cycle
				if (y_q == '0) begin
					g_q <= x_q << sh_q;
					dividend_q <= n_q; rem_q <= '0;
					bit_q <= CW'(64); div_den_q <= 1'b0;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1; y_q <= y_q >> 1; sh_q <= sh_q + 7'd1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= y_q; y_q <= (x_q - y_q) >> 1;
				end else begin
					y_q <= (y_q - x_q) >> 1;
				end
			end
			B_DIV: begin
				// restoring division, one quotient bit per cycle
				if (bit_q == '0) begin
					// numerator quotient done, start on the denominator
					if (!div_den_q) begin
						n_q <= quo_q;
						dividend_q <= d_q; rem_q <= '0;
						bit_q <= CW'(64); div_den_q <= 1'b1;
					end
				end else begin
					if (!rtry[64]) begin
						rem_q <= rtry[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], dividend_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					dividend_q <= dividend_q << 1;
					bit_q <= bit_q - CW'(1);
				end
			end
			B_CHECK: begin
				logic ov;
				ov = ({1'b0, quo_q} > lim - 65'd1) ||
					(neg_q ? {1'b0, n_q} > lim : {1'b0, n_q} > lim - 65'd1);
				if (ov) begin
					rs_q <= ST_OVF;
				end else begin
					rn_q <= neg_q ? 32'(-n_q) : 32'(n_q);
					rd_q <= 31'(quo_q);
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// rational_arithmetic_unit: top level of the rational arithmetic unit
// depends on rau_pkg, rau_front, rau_back
//
// Usage: a request carries an opcode and two fractions on the in channel
// (in_valid/in_stall); one result leaves on the out channel
// (out_valid/out_stall) per request, in order.
// The front accepts a request into a two-entry queue.
// The back works on one request at a time: two cross products, a binary
// gcd that removes one bit per cycle, then two restoring divisions by the
// gcd, numerator then denominator. Comparisons and zero results skip the
// gcd; errors and unused opcodes go straight to the output.
// Throughput is set by the single gcd/divide sequencer in the back.
// Reset empties the queue and idles the sequencer. While the receiver
// stalls, the result holds on the out ports and the queue keeps filling
// until full, then in_stall rises.
module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] a_num,
	input  logic [30:0] a_den,
	input  logic [31:0] b_num,
	input  logic [30:0] b_den,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic        cmp_true,
	output logic [1:0]  status
);

	logic               q_valid, q_pop;
	logic [2:0]         q_type;
	logic [1:0]         q_class;
	logic signed [32:0] q_a_num, q_a_den, q_b_num, q_b_den;

	rau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.in_type(req_type), .in_a_num(a_num), .in_a_den(a_den),
		.in_b_num(b_num), .in_b_den(b_den),
		.q_valid, .q_pop, .q_type, .q_class,
		.q_a_num, .q_a_den, .q_b_num, .q_b_den
	);

	rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_type, .q_class,
		.q_a_num, .q_a_den, .q_b_num, .q_b_den,
		.out_valid, .out_stall, .res_num, .res_den, .cmp_true, .status
	);

endmodule

// ===== sim/rational_arithmetic_unit_checker.sv =====
// rational_arithmetic_unit_checker: watches both channels, predicts each result and compares
// depends on rau_pkg
module rational_arithmetic_unit_checker
	import rau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] a_num,
	input  logic [30:0] a_den,
	input  logic [31:0] b_num,
	input  logic [30:0] b_den,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] res_num,
	input  logic [30:0] res_den,
	input  logic        cmp_true,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] num;
		logic [30:0] den;
		logic        cmp;
		logic [1:0]  st;
	} fraction_result_t;

	fraction_result_t result_fifo[$];

	function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// reduced fraction arithmetic at 32-bit value width
	function automatic fraction_result_t reduce_fraction(logic [2:0] op, logic [31:0] an_b,
			logic [30:0] ad_b, logic [31:0] bn_b, logic [30:0] bd_b);
		fraction_result_t r;
		longint an, ad, bn, bd, num, den, lim;
		longint unsigned mnum, mden, g;
		bit neg;
		r = '0;
		an = longint'(signed'(an_b));
		bn = longint'(signed'(bn_b));
		ad = longint'({1'b0, ad_b});
		bd = longint'({1'b0, bd_b});
		lim = 64'sd1 <<< 31;
		if (op == OP_LT || op == OP_EQ) begin
			r.cmp = (op == OP_LT) ? (an * bd < ad * bn) : (an * bd == ad * bn);
			return r;
		end
		if (op > OP_EQ) return r;
		if (ad == 0 || bd == 0 || (op == OP_DIV && bn == 0)) begin
			r.st = ST_DIV0;
			return r;
		end
		case (op)
			OP_ADD: begin num = an * bd + ad * bn; den = ad * bd; end
			OP_SUB: begin num = an * bd - ad * bn; den = ad * bd; end
			OP_MUL: begin num = an * bn; den = ad * bd; end
			default: begin num = an * bd; den = ad * bn; end
		endcase
		neg = (num < 0) != (den < 0);
		mnum = (num < 0) ? -num : num;
		mden = (den < 0) ? -den : den;
		if (mnum == 0) begin
			r.den = 31'd1;
			return r;
		end
		g = euclid_gcd(mnum, mden);
		mnum = mnum / g;
		mden = mden / g;
		if (mden > lim - 1 || (neg ? mnum > lim : mnum > lim - 1)) begin
			r.st = ST_OVF;
			return r;
		end
		num = neg ? -longint'(mnum) : longint'(mnum);
		r.num = num[31:0];
		r.den = mden[30:0];
		return r;
	endfunction

	// predict on each accepted request, compare each accepted result
	always @(posedge clk) begin
		fraction_result_t exp_r;
		if (!arst_n) begin
			fail_count = 0;
		end else begin
			if (in_valid && !in_stall)
				result_fifo.push_back(reduce_fraction(req_type, a_num, a_den, b_num, b_den));
			if (out_valid && !out_stall) begin
				if (result_fifo.size() == 0) begin
					$error("unexpected result num=%0h den=%0h", res_num, res_den);
					fail_count = fail_count + 1;
				end else begin
					exp_r = result_fifo.pop_front();
					if (res_num !== exp_r.num) begin
						$error("res_num expected %0h actual %0h", exp_r.num, res_num);
						fail_count = fail_count + 1;
					end
					if (res_den !== exp_r.den) begin
						$error("res_den expected %0h actual %0h", exp_r.den, res_den);
						fail_count = fail_count + 1;
					end
					if (cmp_true !== exp_r.cmp) begin
						$error("cmp_true expected %0b actual %0b", exp_r.cmp, cmp_true);
						fail_count = fail_count + 1;
					end
					if (status !== exp_r.st) begin
						$error("status expected %0d actual %0d", exp_r.st, status);
						fail_count = fail_count + 1;
					end
				end
			end
		end
		pending = result_fifo.size();
	end

endmodule

// ===== sim/rational_arithmetic_unit_tb.sv =====
// rational_arithmetic_unit_tb: drives requests into the rational unit and gives the verdict
// depends on rau_pkg, rational_arithmetic_unit, rational_arithmetic_unit_checker
module rational_arithmetic_unit_tb;
	import rau_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1000;
	localparam int QUIET_TAIL = 150;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  req_type;
	logic [31:0] a_num;
	logic [30:0] a_den;
	logic [31:0] b_num;
	logic [30:0] b_den;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] res_num;
	logic [30:0] res_den;
	logic        cmp_true;
	logic [1:0]  status;
	int          fail_count;
	int          pending;
	bit          quiet_phase;
	bit          send_done;

	rational_arithmetic_unit dut (.*);

	rational_arithmetic_unit_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// random operand values, weighted toward edges and small values
	function automatic logic [31:0] pick_num();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'd0;
			3: return 32'($urandom_range(0, 40)) - 32'd20;
			4: return 32'($urandom_range(0, 2000)) - 32'd1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_den();
		case ($urandom_range(0, 7))
			0: return 31'h7fff_ffff;
			1: return 31'd1;
			2: return 31'($urandom_range(1, 30));
			3: return 31'($urandom_range(1, 3000));
			4: return ($urandom_range(0, 30) == 0) ? 31'd0 : 31'd2;
			default: return 31'($urandom) | 31'd1;
		endcase
	endfunction

	task automatic send_request(logic [2:0] op, logic [31:0] an, logic [30:0] ad,
			logic [31:0] bn, logic [30:0] bd);
		int gap;
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		a_num <= an;
		a_den <= ad;
		b_num <= bn;
		b_den <= bd;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// receiver stall: one long hold-off, then random bursts, none at the end
	initial begin
		int burst;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		out_stall <= 1'b1;
		repeat (2000) @(negedge clk);
		out_stall <= 1'b0;
		while (!quiet_phase) begin
			@(negedge clk);
			if ($urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 19);
				out_stall <= 1'b1;
				repeat (burst) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic [2:0] op;
		in_valid = 1'b0;
		req_type = '0;
		a_num = '0;
		a_den = '0;
		b_num = '0;
		b_den = '0;
		quiet_phase = 1'b0;
		send_done = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// directed: each op, extremes, zero result, divide by zero, bad denominators, unused opcodes
		send_request(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
		send_request(OP_SUB, 32'd5, 31'd7, 32'd5, 31'd7);
		send_request(OP_MUL, 32'hffff_fffd, 31'd4, 32'd8, 31'd9);
		send_request(OP_DIV, 32'd3, 31'd5, 32'hffff_fff9, 31'd2);
		send_request(OP_DIV, 32'd3, 31'd5, 32'd0, 31'd2);
		send_request(OP_ADD, 32'd3, 31'd0, 32'd1, 31'd2);
		send_request(OP_MUL, 32'd3, 31'd4, 32'd1, 31'd0);
		send_request(OP_LT, 32'd1, 31'd0, 32'd1, 31'd0);
		send_request(OP_ADD, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
		send_request(OP_SUB, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
		send_request(OP_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
		send_request(OP_MUL, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
		send_request(OP_DIV, 32'h8000_0000, 31'd1, 32'hffff_ffff, 31'd1);
		send_request(OP_MUL, 32'd1, 31'h7fff_ffff, 32'd1, 31'h7fff_ffff);
		send_request(OP_DIV, 32'd1, 31'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
		send_request(OP_LT, 32'hffff_ffff, 31'd2, 32'd1, 31'd3);
		send_request(OP_LT, 32'd1, 31'd2, 32'd1, 31'd2);
		send_request(OP_EQ, 32'd2, 31'd4, 32'd1, 31'd2);
		send_request(OP_EQ, 32'd2, 31'd4, 32'd1, 31'd3);
		send_request(3'd6, 32'd1, 31'd1, 32'd1, 31'd1);
		send_request(3'd7, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
		send_request(OP_ADD, 32'd0, 31'd5, 32'd0, 31'd9);
		// random requests, last part without idling
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 100) quiet_phase = 1'b1;
			op = ($urandom_range(0, 20) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			send_request(op, pick_num(), pick_den(), pick_num(), pick_den());
		end
		in_valid <= 1'b0;
		quiet_phase = 1'b1;
		while (pending != 0) @(negedge clk);
		repeat (QUIET_TAIL) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== rational_arithmetic_unit.f =====
rtl/core/rau_pkg.sv
rtl/core/rau_front.sv
rtl/core/rau_back.sv
rtl/core/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_checker.sv
sim/rational_arithmetic_unit_tb.sv
